// ----- rtl/cdsr_pkg.sv -----
// shared types and constants for the clipped disk span rasterizer
// no dependencies; used by every module of the block
package cdsr_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 11;
  localparam int CFG_IDX_BITS    = 2;

  // what the back end has to do with a queued item
  typedef enum logic [1:0] {
    CMD_NEXT    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_CLIPPED = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // signed width that holds coordinates, radius offsets and their sums
  function automatic int ext_bits(input int cb, input int rb);
    return ((cb > rb) ? cb : rb + 1) + 2;
  endfunction

endpackage

// ----- rtl/cdsr_front.sv -----
// front end: accepts input beats, clips a new disk against the window
// and queues a command; depends on cdsr_pkg
module cdsr_front
  import cdsr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_disk,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_disk_radius,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_lo_x,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_hi_x,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_top,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_bot,
  input  q_status_t                     q_stat,
  output logic                          push,
  output logic [$bits(cmd_t)+4*COORD_BITS+RADIUS_BITS-1:0] push_data
);

  localparam int EW = ext_bits(COORD_BITS, RADIUS_BITS);

  logic signed [EW-1:0] r_e, cx_e, cy_e;
  logic signed [EW-1:0] top_e, bot_e, left_e, right_e;
  logic signed [EW-1:0] first_e, last_e, lo_e, hi_e;
  logic                 live;
  cmd_t                 code;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    r_e     = EW'($signed({1'b0, in_disk_radius}));
    cx_e    = EW'(in_center_x);
    cy_e    = EW'(in_center_y);
    top_e   = cy_e - r_e;
    bot_e   = cy_e + r_e - EW'(1);
    left_e  = cx_e - r_e;
    right_e = cx_e + r_e - EW'(1);
    first_e = (top_e > win_top) ? top_e : win_top;
    last_e  = (bot_e < win_bot) ? bot_e : win_bot;
    lo_e    = (left_e > win_lo_x) ? left_e : win_lo_x;
    hi_e    = (right_e < win_hi_x) ? right_e : win_hi_x;
    live    = (in_disk_radius != '0) && (first_e <= last_e) && (lo_e <= hi_e);
    if (!in_new_disk) begin
      code = CMD_NEXT;
    end else if (live) begin
      code = CMD_LOAD;
    end else begin
      code = CMD_CLIPPED;
    end
  end

  // first and last rows lie in the coordinate range whenever the disk is live
  assign push_data = {code, in_center_x, in_center_y, in_disk_radius,
                      first_e[COORD_BITS-1:0], last_e[COORD_BITS-1:0]};

endmodule

// ----- rtl/cdsr_queue.sv -----
// two-entry command queue between the front and back ends
// depends on cdsr_pkg for the status struct
module cdsr_queue
  import cdsr_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_status_t        q_stat
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/cdsr_back.sv -----
// back end: holds the disk in progress, runs the row square root and
// drives the registered span output; depends on cdsr_pkg
module cdsr_back
  import cdsr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  q_status_t                     q_stat,
  input  logic [$bits(cmd_t)+4*COORD_BITS+RADIUS_BITS-1:0] pop_data,
  output logic                          pop,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_lo_x,
  input  logic signed [ext_bits(COORD_BITS, RADIUS_BITS)-1:0] win_hi_x,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_span_x,
  output logic signed [COORD_BITS-1:0]  out_span_y,
  output logic [RADIUS_BITS:0]          out_span_len,
  output logic                          out_last_row,
  output logic                          out_no_rows
);

  localparam int CB   = COORD_BITS;
  localparam int RB   = RADIUS_BITS;
  localparam int EW   = ext_bits(COORD_BITS, RADIUS_BITS);
  localparam int QW   = $bits(cmd_t) + 4*COORD_BITS + RADIUS_BITS;
  localparam int NI   = ((RADIUS_BITS + 2) / 2) * 2;  // root iterations, even
  localparam int SW   = 2 * NI;
  localparam int RSQW = 2 * RADIUS_BITS;
  localparam int SQW  = 2 * RADIUS_BITS + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIFF = 5'b00100,
    S_ROOT = 5'b01000,
    S_SPAN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CB-1:0] held_cx_r, held_cx_nxt;
  logic signed [CB-1:0] held_cy_r, held_cy_nxt;
  logic [RB-1:0]        held_rad_r, held_rad_nxt;
  logic signed [CB-1:0] cur_row_r, cur_row_nxt;
  logic signed [CB-1:0] end_row_r, end_row_nxt;
  logic                 active_r, active_nxt;

  logic [RSQW-1:0]      rsq_r, rsq_nxt;
  logic [SQW-1:0]       dysq_r, dysq_nxt;
  logic [SW-1:0]        n_r, n_nxt;
  logic [SW-1:0]        root_r, root_nxt;
  logic [SW-1:0]        bit_r, bit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CB-1:0] span_x_r, span_x_nxt;
  logic signed [CB-1:0] span_y_r, span_y_nxt;
  logic [RB:0]          span_len_r, span_len_nxt;
  logic                 last_row_r, last_row_nxt;
  logic                 no_rows_r, no_rows_nxt;

  // queue entry fields
  cmd_t                 q_code;
  logic signed [CB-1:0] q_cx, q_cy, q_first, q_last;
  logic [RB-1:0]        q_rad;

  logic                 direct, out_free;

  // row arithmetic
  logic signed [EW-1:0] dy_e, dy_abs;
  logic [RB:0]          dya;
  logic [SW-1:0]        n_a, root_a, bit_a;
  logic [RB:0]          t_v;
  logic [RB-1:0]        k_v;
  logic signed [EW-1:0] k_e, cx_e, lo_raw, hi_raw, lo_e, hi_e, len_e;
  logic                 is_last;

  assign q_code  = cmd_t'(pop_data[QW-1 -: $bits(cmd_t)]);
  assign q_cx    = pop_data[4*CB+RB-1 -: CB];
  assign q_cy    = pop_data[3*CB+RB-1 -: CB];
  assign q_rad   = pop_data[2*CB+RB-1 -: RB];
  assign q_first = pop_data[2*CB-1 -: CB];
  assign q_last  = pop_data[CB-1:0];

  // items that answer with no row go straight to the output register
  assign direct   = (q_code == CMD_CLIPPED) || ((q_code == CMD_NEXT) && !active_r);
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty && (!direct || out_free);

  // two restoring square-root steps per cycle
  always_comb begin
    n_a    = n_r;
    root_a = root_r;
    bit_a  = bit_r;
    for (int i = 0; i < 2; i++) begin
      if (n_a >= root_a + bit_a) begin
        n_a    = n_a - (root_a + bit_a);
        root_a = (root_a >> 1) + bit_a;
      end else begin
        root_a = root_a >> 1;
      end
      bit_a = bit_a >> 2;
    end
  end

  always_comb begin
    dy_e   = ((EW'(cur_row_r) - EW'(held_cy_r)) <<< 1) + EW'(1);
    dy_abs = dy_e[EW-1] ? -dy_e : dy_e;
    dya    = dy_abs[RB:0];

    // largest odd t with t*t <= d, then k = (t-1)/2
    t_v     = root_r[RB:0];
    k_v     = t_v[RB:1] - RB'(!t_v[0]);
    k_e     = EW'($signed({1'b0, k_v}));
    cx_e    = EW'(held_cx_r);
    lo_raw  = cx_e - k_e - EW'(1);
    hi_raw  = cx_e + k_e;
    lo_e    = (lo_raw > win_lo_x) ? lo_raw : win_lo_x;
    hi_e    = (hi_raw < win_hi_x) ? hi_raw : win_hi_x;
    len_e   = hi_e - lo_e + EW'(1);
    is_last = (cur_row_r >= end_row_r);
  end

  always_comb begin
    state_nxt    = state_r;
    held_cx_nxt  = held_cx_r;
    held_cy_nxt  = held_cy_r;
    held_rad_nxt = held_rad_r;
    cur_row_nxt  = cur_row_r;
    end_row_nxt  = end_row_r;
    active_nxt   = active_r;
    rsq_nxt      = rsq_r;
    dysq_nxt     = dysq_r;
    n_nxt        = n_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    span_len_nxt = span_len_r;
    last_row_nxt = last_row_r;
    no_rows_nxt  = no_rows_r;

    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (direct) begin
            active_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
            span_x_nxt    = '0;
            span_y_nxt    = '0;
            span_len_nxt  = '0;
            last_row_nxt  = 1'b0;
            no_rows_nxt   = 1'b1;
          end else begin
            if (q_code == CMD_LOAD) begin
              held_cx_nxt  = q_cx;
              held_cy_nxt  = q_cy;
              held_rad_nxt = q_rad;
              cur_row_nxt  = q_first;
              end_row_nxt  = q_last;
              active_nxt   = 1'b1;
            end
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        rsq_nxt   = RSQW'(held_rad_r) * RSQW'(held_rad_r);
        dysq_nxt  = SQW'(dya) * SQW'(dya);
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        // rows of the disk always leave d = 4r^2 - dy^2 positive
        n_nxt     = SW'({rsq_r, 2'b00}) - SW'(dysq_r);
        root_nxt  = '0;
        bit_nxt   = SW'(1) << (SW - 2);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        n_nxt    = n_a;
        root_nxt = root_a;
        bit_nxt  = bit_a;
        if (bit_r[2]) begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          span_y_nxt    = cur_row_r;
          last_row_nxt  = is_last;
          no_rows_nxt   = 1'b0;
          if (len_e > EW'(0)) begin
            span_x_nxt   = lo_e[CB-1:0];
            span_len_nxt = len_e[RB:0];
          end else begin
            span_x_nxt   = '0;
            span_len_nxt = '0;
          end
          if (is_last) begin
            active_nxt = 1'b0;
          end else begin
            cur_row_nxt = cur_row_r + CB'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      held_cx_r   <= '0;
      held_cy_r   <= '0;
      held_rad_r  <= '0;
      cur_row_r   <= '0;
      end_row_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      held_cx_r   <= held_cx_nxt;
      held_cy_r   <= held_cy_nxt;
      held_rad_r  <= held_rad_nxt;
      cur_row_r   <= cur_row_nxt;
      end_row_r   <= end_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsq_r      <= rsq_nxt;
    dysq_r     <= dysq_nxt;
    n_r        <= n_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    span_x_r   <= span_x_nxt;
    span_y_r   <= span_y_nxt;
    span_len_r <= span_len_nxt;
    last_row_r <= last_row_nxt;
    no_rows_r  <= no_rows_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_span_x   = span_x_r;
  assign out_span_y   = span_y_r;
  assign out_span_len = span_len_r;
  assign out_last_row = last_row_r;
  assign out_no_rows  = no_rows_r;

endmodule

// ----- rtl/clipped_disk_span_rasterizer.sv -----
// top level of the clipped disk span rasterizer: clip window registers,
// front end, command queue and back end; depends on cdsr_pkg
//
// Every input beat yields exactly one span beat. A beat with new_disk set
// loads a center and radius and gives the disk's first row inside the clip
// window; a beat with new_disk clear gives the next row. A disk that is
// fully clipped, or a next-row request with no disk in progress, gives a
// beat with no_rows set and all span fields zero. The front end takes an
// input beat in the same cycle whenever its two-entry queue has room, so
// up to two requests can wait while a row is worked on. A beat that answers
// with no_rows goes from the queue straight to the output register. A
// beat that produces a row passes in order through dequeue, the squares,
// the difference, NI square-root steps, NI being RADIUS_BITS+1 rounded up
// to even, in a unit that resolves two root bits per cycle, and the clip
// and load of the output register, which waits under out_stall. The span
// output is registered, so a finished beat may wait under out_stall while
// the next row is already being computed up to that last step.
module clipped_disk_span_rasterizer
  import cdsr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_disk,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_disk_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_span_x,
  output logic signed [COORD_BITS-1:0]  out_span_y,
  output logic [RADIUS_BITS:0]          out_span_len,
  output logic                          out_last_row,
  output logic                          out_no_rows,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data
);

  localparam int EW = ext_bits(COORD_BITS, RADIUS_BITS);
  localparam int QW = $bits(cmd_t) + 4*COORD_BITS + RADIUS_BITS;
  localparam logic signed [EW-1:0] CMAX_E = EW'((1 << (COORD_BITS - 1)) - 1);

  logic signed [COORD_BITS-1:0] clip_left_r, clip_top_r;
  logic [COORD_BITS-2:0]        clip_width_r, clip_height_r;

  logic signed [EW-1:0] win_lo_x, win_hi_x, win_top, win_bot, hi_raw, bot_raw;

  logic          push, pop;
  logic [QW-1:0] push_data, pop_data;
  q_status_t     q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLIP_LEFT:   clip_left_r   <= cfg_data;
        REG_CLIP_TOP:    clip_top_r    <= cfg_data;
        REG_CLIP_WIDTH:  clip_width_r  <= cfg_data[COORD_BITS-2:0];
        REG_CLIP_HEIGHT: clip_height_r <= cfg_data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // window edges; the right and bottom edges are capped at the signed coordinate maximum
  always_comb begin
    hi_raw   = EW'(clip_left_r) + EW'($signed({1'b0, clip_width_r})) - EW'(1);
    bot_raw  = EW'(clip_top_r) + EW'($signed({1'b0, clip_height_r})) - EW'(1);
    win_lo_x = EW'(clip_left_r);
    win_top  = EW'(clip_top_r);
    win_hi_x = (hi_raw > CMAX_E) ? CMAX_E : hi_raw;
    win_bot  = (bot_raw > CMAX_E) ? CMAX_E : bot_raw;
  end

  cdsr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_new_disk    (in_new_disk),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_disk_radius (in_disk_radius),
    .win_lo_x       (win_lo_x),
    .win_hi_x       (win_hi_x),
    .win_top        (win_top),
    .win_bot        (win_bot),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  cdsr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  cdsr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .pop_data     (pop_data),
    .pop          (pop),
    .win_lo_x     (win_lo_x),
    .win_hi_x     (win_hi_x),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_span_x   (out_span_x),
    .out_span_y   (out_span_y),
    .out_span_len (out_span_len),
    .out_last_row (out_last_row),
    .out_no_rows  (out_no_rows)
  );

endmodule

// ----- rtl/cdsr_checker.sv -----
// port-level checks for the clipped disk span rasterizer, bound to the top
// depends on cdsr_pkg and the top level's port list
module cdsr_checker
  import cdsr_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_BITS-1:0]  out_span_x,
  input logic signed [COORD_BITS-1:0]  out_span_y,
  input logic [RADIUS_BITS:0]          out_span_len,
  input logic                          out_last_row,
  input logic                          out_no_rows
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // an empty answer carries no span at all
  a_no_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_rows |->
      out_span_x == '0 && out_span_y == '0 && out_span_len == '0 && !out_last_row)
    else $error("no_rows beat with nonzero span fields");

  // a row clipped away sideways reports column zero
  a_empty_row_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_rows && out_span_len == '0 |-> out_span_x == '0)
    else $error("empty row with nonzero span_x");

endmodule

bind clipped_disk_span_rasterizer cdsr_checker #(
  .COORD_BITS  (COORD_BITS),
  .RADIUS_BITS (RADIUS_BITS)
) u_cdsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_span_x   (out_span_x),
  .out_span_y   (out_span_y),
  .out_span_len (out_span_len),
  .out_last_row (out_last_row),
  .out_no_rows  (out_no_rows)
);
